@@ rtl/core/wth_pkg.sv @@
`default_nettype none
package wth_pkg;

    // Byte codes that steer the tokenizer.
    localparam logic [7:0] BYTE_CR    = 8'd13;
    localparam logic [7:0] BYTE_NL    = 8'd10;
    localparam logic [7:0] BYTE_TAB   = 8'd9;
    localparam logic [7:0] BYTE_SPACE = 8'd32;

    localparam int unsigned MAX_WORD_CHARS_DEF = 58;
    localparam int unsigned HASH_W             = 64;
    localparam int unsigned BUCKET_W           = 31;
    localparam int unsigned LEN_OUT_W          = 6;
    localparam logic [BUCKET_W-1:0] BUCKET_RESET = 31'd500000000;

    localparam logic TOKEN_WORD   = 1'b0;
    localparam logic TOKEN_MARKER = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_LOAD,
        ST_DIV,
        ST_WORD,
        ST_MARK
    } t_state;

    typedef enum logic [2:0] {
        DP_HOLD,
        DP_MUL,
        DP_ADD,
        DP_LOAD,
        DP_DIV,
        DP_CLEAR
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [7:0] text_byte;
    } t_dp_ctrl;

    typedef struct packed {
        logic                 word_open;
        logic                 word_full;
        logic                 div_last;
        logic [BUCKET_W-1:0]  rem;
        logic [LEN_OUT_W-1:0] len;
    } t_dp_stat;

endpackage
`default_nettype wire

@@ rtl/core/wth_datapath.sv @@
`default_nettype none
module wth_datapath #(
    parameter int unsigned MAX_WORD_CHARS = wth_pkg::MAX_WORD_CHARS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire wth_pkg::t_dp_ctrl                i_ctrl,
    input  wire logic [wth_pkg::BUCKET_W-1:0]     i_bucket,
    output wth_pkg::t_dp_stat                     o_stat
);
    import wth_pkg::*;

    localparam int unsigned LEN_W = $clog2(MAX_WORD_CHARS + 1);
    localparam int unsigned CNT_W = $clog2(HASH_W);

    logic [HASH_W-1:0]   r_hash, n_hash;
    logic [LEN_W-1:0]    r_chars, n_chars;
    logic [HASH_W-1:0]   r_div, n_div;
    logic [BUCKET_W-1:0] r_rem, n_rem;
    logic [CNT_W-1:0]    r_cnt, n_cnt;

    // The one shared adder: hash * 257 as h + (h << 8), the byte add, and the
    // trial subtract of the restoring division all go through it.
    logic [HASH_W-1:0]     add_a, add_b, add_sum;
    logic                  add_cin;
    logic [BUCKET_W:0]     trial;

    assign trial   = {r_rem, r_div[HASH_W-1]};
    assign add_sum = add_a + add_b + HASH_W'(add_cin);

    always_comb begin
        add_a   = r_hash;
        add_b   = r_hash << 8;
        add_cin = 1'b0;
        case (i_ctrl.op)
            DP_ADD: begin
                add_b = {{(HASH_W-8){i_ctrl.text_byte[7]}}, i_ctrl.text_byte};
            end
            DP_DIV: begin
                add_a   = HASH_W'(trial);
                add_b   = ~HASH_W'(i_bucket);
                add_cin = 1'b1;
            end
            default: begin
                add_a   = r_hash;
                add_b   = r_hash << 8;
                add_cin = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_hash  = r_hash;
        n_chars = r_chars;
        n_div   = r_div;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        case (i_ctrl.op)
            DP_MUL: begin
                n_hash = add_sum;
            end
            DP_ADD: begin
                n_hash  = add_sum;
                n_chars = r_chars + LEN_W'(1);
            end
            DP_LOAD: begin
                n_div = r_hash;
                n_rem = '0;
                n_cnt = '0;
            end
            DP_DIV: begin
                // A clear sign bit means the trial remainder covers the bucket count.
                n_rem = add_sum[HASH_W-1] ? trial[BUCKET_W-1:0] : add_sum[BUCKET_W-1:0];
                n_div = r_div << 1;
                n_cnt = r_cnt + CNT_W'(1);
            end
            DP_CLEAR: begin
                n_hash  = HASH_W'(1);
                n_chars = '0;
            end
            default: begin
                n_hash = r_hash;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash  <= HASH_W'(1);
            r_chars <= '0;
        end else begin
            r_hash  <= n_hash;
            r_chars <= n_chars;
        end
        r_div <= n_div;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
    end

    assign o_stat.word_open = (r_chars != '0);
    assign o_stat.word_full = (r_chars >= LEN_W'(MAX_WORD_CHARS));
    assign o_stat.div_last  = (r_cnt == CNT_W'(HASH_W - 1));
    assign o_stat.rem       = r_rem;
    assign o_stat.len       = LEN_OUT_W'(r_chars);

endmodule
`default_nettype wire

@@ rtl/core/word_tokenizer_hasher.sv @@
// Whitespace tokenizer with a base-257 word hash.
//
// Input channel: one text byte per item on i_text_byte, taken when i_valid is
// high and o_stall is low. Carriage returns are dropped, space and tab close
// an open word, and a newline closes an open word and then adds a sentence-end
// marker item. Output channel: items on o_token_kind, o_word_hash,
// o_word_length and o_last_of_run, taken when o_valid is high and i_stall is
// low. The user must write the bucket count through i_cfg_valid / i_cfg_data
// only while idle; the block does not enforce it. o_cfg_ready is always high.
//
// Sequencing: an ordinary character is accepted, then passes twice through the
// shared 64-bit adder, for h*257 and for the byte add; a character past the
// length limit and a carriage return are taken without leaving the idle
// state. Closing a word runs accept, load, 64 restoring-division steps on the
// same adder and output load; after a newline, the marker follows the word
// result. The output register lets the block take the next byte while a
// result waits. When the receiver stalls, the result holds in the output
// register and a second result waits until it is taken. A synchronous
// active-low reset sets the hash to 1, the length to 0, the bucket count to
// 500000000 and drops any pending result.
`default_nettype none
module word_tokenizer_hasher #(
    parameter int unsigned MAX_WORD_CHARS = wth_pkg::MAX_WORD_CHARS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [7:0]                        i_text_byte,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic                                   o_token_kind,
    output logic [wth_pkg::BUCKET_W-1:0]           o_word_hash,
    output logic [wth_pkg::LEN_OUT_W-1:0]          o_word_length,
    output logic                                   o_last_of_run,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [wth_pkg::BUCKET_W-1:0]      i_cfg_data
);
    import wth_pkg::*;

    t_state   r_state, n_state;
    t_dp_ctrl dp_ctrl;
    t_dp_stat dp_stat;

    logic [7:0]          r_byte;
    logic                r_nl, n_nl;
    logic [BUCKET_W-1:0] r_bucket;

    // Output register.
    logic                 r_o_valid, n_o_valid;
    logic                 r_o_kind, n_o_kind;
    logic [BUCKET_W-1:0]  r_o_hash, n_o_hash;
    logic [LEN_OUT_W-1:0] r_o_len, n_o_len;
    logic                 r_o_last, n_o_last;

    logic in_take;
    logic out_free;
    logic is_space;

    assign o_stall     = (r_state != ST_IDLE);
    assign in_take     = i_valid && !o_stall;
    assign out_free    = !r_o_valid || !i_stall;
    assign is_space    = (i_text_byte == BYTE_SPACE) || (i_text_byte == BYTE_TAB) ||
                         (i_text_byte == BYTE_NL);
    assign o_cfg_ready = 1'b1;

    wth_datapath #(
        .MAX_WORD_CHARS(MAX_WORD_CHARS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (dp_ctrl),
        .i_bucket (r_bucket),
        .o_stat   (dp_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
            r_bucket  <= BUCKET_RESET;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_bucket <= i_cfg_data;
            end
        end
        if (in_take) begin
            r_byte <= i_text_byte;
        end
        r_nl     <= n_nl;
        r_o_kind <= n_o_kind;
        r_o_hash <= n_o_hash;
        r_o_len  <= n_o_len;
        r_o_last <= n_o_last;
    end

    always_comb begin
        n_state           = r_state;
        n_nl              = r_nl;
        dp_ctrl.op        = DP_HOLD;
        dp_ctrl.text_byte = r_byte;
        n_o_valid         = r_o_valid && i_stall;
        n_o_kind          = r_o_kind;
        n_o_hash          = r_o_hash;
        n_o_len           = r_o_len;
        n_o_last          = r_o_last;
        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_nl = (i_text_byte == BYTE_NL);
                    if (i_text_byte == BYTE_CR) begin
                        n_state = ST_IDLE;
                    end else if (is_space) begin
                        if (dp_stat.word_open) begin
                            n_state = ST_LOAD;
                        end else if (i_text_byte == BYTE_NL) begin
                            n_state = ST_MARK;
                        end
                    end else if (!dp_stat.word_full) begin
                        n_state = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                dp_ctrl.op = DP_MUL;
                n_state    = ST_ADD;
            end
            ST_ADD: begin
                dp_ctrl.op = DP_ADD;
                n_state    = ST_IDLE;
            end
            ST_LOAD: begin
                dp_ctrl.op = DP_LOAD;
                n_state    = ST_DIV;
            end
            ST_DIV: begin
                dp_ctrl.op = DP_DIV;
                if (dp_stat.div_last) begin
                    n_state = ST_WORD;
                end
            end
            ST_WORD: begin
                if (out_free) begin
                    dp_ctrl.op = DP_CLEAR;
                    n_o_valid  = 1'b1;
                    n_o_kind   = TOKEN_WORD;
                    // A zero bucket count reports bucket zero.
                    n_o_hash   = (r_bucket == '0) ? '0 : dp_stat.rem;
                    n_o_len    = dp_stat.len;
                    n_o_last   = !r_nl;
                    n_state    = r_nl ? ST_MARK : ST_IDLE;
                end
            end
            ST_MARK: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_kind  = TOKEN_MARKER;
                    n_o_hash  = '0;
                    n_o_len   = '0;
                    n_o_last  = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_valid       = r_o_valid;
    assign o_token_kind  = r_o_kind;
    assign o_word_hash   = r_o_hash;
    assign o_word_length = r_o_len;
    assign o_last_of_run = r_o_last;

endmodule
`default_nettype wire

@@ rtl/core/wth_checker.sv @@
`default_nettype none
module wth_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_valid,
    input wire logic                              o_stall,
    input wire logic [7:0]                        i_text_byte,
    input wire logic                              o_valid,
    input wire logic                              i_stall,
    input wire logic                              o_token_kind,
    input wire logic [wth_pkg::BUCKET_W-1:0]      o_word_hash,
    input wire logic [wth_pkg::LEN_OUT_W-1:0]     o_word_length,
    input wire logic                              o_last_of_run
);
    import wth_pkg::*;

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_token_kind) &&
        $stable(o_word_hash) && $stable(o_word_length) && $stable(o_last_of_run))
        else $error("stalled result changed");

    // A sentence-end marker carries no hash, no length, and ends its run.
    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_token_kind == TOKEN_MARKER) |->
        (o_word_hash == '0) && (o_word_length == '0) && o_last_of_run)
        else $error("malformed marker");

    // A word result always has at least one kept character.
    a_word_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_token_kind == TOKEN_WORD) |-> (o_word_length != '0))
        else $error("empty word result");

    // A carriage return is dropped on the spot and leaves the block ready.
    a_cr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_text_byte == BYTE_CR) |=> !o_stall)
        else $error("carriage return occupied the block");

    // Reset drops any pending result.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result survived reset");

endmodule

bind word_tokenizer_hasher wth_checker u_wth_checker (.*);
`default_nettype wire

@@ bench/wth_token_checker.sv @@
`timescale 1ns / 1ps

module wth_token_checker #(
    parameter int unsigned MAX_CHARS = wth_pkg::MAX_WORD_CHARS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    input  wire logic                            i_in_stall,
    input  wire logic [7:0]                      i_text_byte,
    input  wire logic                            i_out_valid,
    input  wire logic                            i_out_stall,
    input  wire logic                            i_token_kind,
    input  wire logic [wth_pkg::BUCKET_W-1:0]    i_word_hash,
    input  wire logic [wth_pkg::LEN_OUT_W-1:0]   i_word_length,
    input  wire logic                            i_last_of_run,
    input  wire logic                            i_cfg_valid,
    input  wire logic                            i_cfg_ready,
    input  wire logic [wth_pkg::BUCKET_W-1:0]    i_cfg_data,
    output int                                   o_fail_count,
    output int                                   o_tokens_pending
);
    import wth_pkg::*;

    localparam logic [HASH_W-1:0] HASH_MULT = 64'd257;

    typedef struct packed {
        logic                 kind;
        logic [BUCKET_W-1:0]  hash;
        logic [LEN_OUT_W-1:0] length;
        logic                 last;
    } t_token;

    logic [BUCKET_W-1:0]  buckets       = BUCKET_RESET;
    logic [HASH_W-1:0]    word_hash_acc = 64'd1;
    logic [LEN_OUT_W-1:0] word_chars    = '0;
    t_token               tokens_due[$];
    int                   fails         = 0;

    assign o_fail_count     = fails;
    assign o_tokens_pending = tokens_due.size();

    function automatic logic [BUCKET_W-1:0] bucket_of(input logic [HASH_W-1:0] h);
        logic [HASH_W-1:0] r;
        if (buckets == '0) begin
            return '0;
        end
        r = h % 64'(buckets);
        return r[BUCKET_W-1:0];
    endfunction

    // Advances the word state by one text byte and queues the tokens it closes.
    function automatic void tokenize_byte(input logic [7:0] b);
        t_token tok;
        if (b == BYTE_CR) begin
            return;
        end
        if (b == BYTE_SPACE || b == BYTE_TAB || b == BYTE_NL) begin
            if (word_chars != '0) begin
                tok.kind   = TOKEN_WORD;
                tok.hash   = bucket_of(word_hash_acc);
                tok.length = word_chars;
                tok.last   = (b != BYTE_NL);
                tokens_due.push_back(tok);
                word_hash_acc = 64'd1;
                word_chars    = '0;
            end
            if (b == BYTE_NL) begin
                tok.kind   = TOKEN_MARKER;
                tok.hash   = '0;
                tok.length = '0;
                tok.last   = 1'b1;
                tokens_due.push_back(tok);
            end
        end else if (word_chars < MAX_CHARS) begin
            // The byte joins the hash as a signed char would.
            word_hash_acc = word_hash_acc * HASH_MULT + {{56{b[7]}}, b};
            word_chars    = word_chars + 1'b1;
        end
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_token due;
        if (!i_rst_n) begin
            buckets       = BUCKET_RESET;
            word_hash_acc = 64'd1;
            word_chars    = '0;
            tokens_due.delete();
        end else begin
            // Results come out before the byte taken at this edge can cause any.
            if (i_out_valid && !i_out_stall) begin
                if (tokens_due.size() == 0) begin
                    $error("unexpected token: kind %0d hash %0d length %0d last %0d",
                           i_token_kind, i_word_hash, i_word_length, i_last_of_run);
                    fails++;
                end else begin
                    due = tokens_due.pop_front();
                    check_field("token_kind", due.kind, i_token_kind);
                    check_field("word_hash", due.hash, i_word_hash);
                    check_field("word_length", due.length, i_word_length);
                    check_field("last_of_run", due.last, i_last_of_run);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                buckets = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                tokenize_byte(i_text_byte);
            end
        end
    end

endmodule

@@ bench/word_tokenizer_hasher_tb.sv @@
`timescale 1ns / 1ps

// Top of the tokenizer bench. This module only makes stimulus and gives the
// verdict; the checker beside the block watches all three channels, predicts
// the tokens and compares them.
module word_tokenizer_hasher_tb;
    import wth_pkg::*;

    // Each side idles in about this many cycles out of a hundred.
    localparam int unsigned IDLE_PCT        = 32;
    localparam int unsigned PHASES          = 7;
    localparam int unsigned ITEMS_PER_PHASE = 225;
    // Long enough to cover a word close with room to spare.
    localparam int unsigned SETTLE_CYCLES   = 100;
    localparam int unsigned LIMIT_NS        = 2_000_000;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_stall;
    logic [7:0]           i_text_byte = '0;
    logic                 o_valid;
    logic                 i_stall     = 1'b0;
    logic                 o_token_kind;
    logic [BUCKET_W-1:0]  o_word_hash;
    logic [LEN_OUT_W-1:0] o_word_length;
    logic                 o_last_of_run;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [BUCKET_W-1:0]  i_cfg_data  = '0;

    int                   fail_count;
    int                   tokens_pending;
    // While set, neither side idles, so the block runs at its full rate.
    logic                 no_idle     = 1'b0;

    word_tokenizer_hasher i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_text_byte   (i_text_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_token_kind  (o_token_kind),
        .o_word_hash   (o_word_hash),
        .o_word_length (o_word_length),
        .o_last_of_run (o_last_of_run),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    wth_token_checker u_token_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_text_byte      (i_text_byte),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_token_kind     (o_token_kind),
        .i_word_hash      (o_word_hash),
        .i_word_length    (o_word_length),
        .i_last_of_run    (o_last_of_run),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_tokens_pending (tokens_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // The receiver decides its stall at each falling edge, independently of
    // whatever the block is offering.
    always @(negedge i_clk) begin
        i_stall = !no_idle && ($urandom_range(99) < IDLE_PCT);
    end

    // The directed opening. It covers a one-letter word, a word built from the
    // zero byte and the bytes where the sign extension flips, separators with
    // no open word, a bare newline, a carriage return inside a word that is
    // closed by a newline, and control characters that sit next to the
    // separator codes but count as ordinary characters.
    logic [7:0] opening_text [$] = '{
        8'h61, BYTE_SPACE,
        8'h00, 8'hFF, 8'h80, 8'h7F, BYTE_TAB,
        BYTE_TAB, BYTE_SPACE, BYTE_NL, BYTE_CR,
        8'h71, BYTE_CR, 8'h7A, BYTE_NL,
        BYTE_CR, BYTE_NL,
        8'h08, 8'h0B, 8'h0C, 8'h0E, 8'h1F, 8'h21, BYTE_SPACE
    };

    // Offers one text item and returns at the falling edge after it is taken.
    // Valid stays high there, so a back-to-back item never drops it.
    task automatic send_byte(input logic [7:0] value);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid     = 1'b1;
        i_text_byte = value;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // A random byte that is neither a separator nor a carriage return.
    function automatic logic [7:0] plain_char();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(255));
        end while (b == BYTE_SPACE || b == BYTE_TAB || b == BYTE_NL || b == BYTE_CR);
        return b;
    endfunction

    // Mostly well-formed words with random content and a random separator,
    // with some raw noise bytes mixed in. About one word in twenty has 50 to 70
    // characters, mostly past the limit, so the truncation path gets regular use.
    task automatic feed_text(input int unsigned n_items);
        int unsigned sent;
        int unsigned chars_in_word;
        int unsigned pick;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                send_byte(8'($urandom_range(255)));
                sent++;
            end else begin
                chars_in_word = ($urandom_range(19) == 0) ? $urandom_range(70, 50)
                                                         : $urandom_range(12, 1);
                repeat (chars_in_word) begin
                    if ($urandom_range(19) == 0) begin
                        send_byte(BYTE_CR);
                    end
                    send_byte(plain_char());
                    sent++;
                end
                pick = $urandom_range(9);
                if (pick < 4) begin
                    send_byte(BYTE_SPACE);
                end else if (pick < 6) begin
                    send_byte(BYTE_TAB);
                end else if (pick < 8) begin
                    send_byte(BYTE_NL);
                end else if (pick == 8) begin
                    // A DOS line ending: the carriage return vanishes.
                    send_byte(BYTE_CR);
                    send_byte(BYTE_NL);
                end else begin
                    // Runs of separators, ending in a blank line.
                    send_byte(BYTE_SPACE);
                    send_byte(BYTE_TAB);
                    send_byte(BYTE_NL);
                    send_byte(BYTE_NL);
                    sent += 3;
                end
                sent++;
            end
        end
    endtask

    // Stops the text stream and waits until every token has come out, then
    // lets the block finish any character it may still be hashing.
    task automatic settle();
        i_valid = 1'b0;
        while (tokens_pending != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_buckets(input logic [BUCKET_W-1:0] value);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    initial begin
        logic [BUCKET_W-1:0] setting;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // The first phase runs on the bucket count left by reset.
        foreach (opening_text[k]) begin
            send_byte(opening_text[k]);
        end

        for (int p = 0; p < PHASES; p++) begin
            if (p != 0) begin
                settle();
                // The smallest count, the largest, zero (which forces a zero
                // hash), a small random one, a full-width random one, and
                // finally the reset value written back explicitly.
                case (p)
                    1:       setting = 31'd1;
                    2:       setting = '1;
                    3:       setting = '0;
                    4:       setting = 31'($urandom_range(1000, 2));
                    5:       setting = 31'($urandom);
                    default: setting = BUCKET_RESET;
                endcase
                write_buckets(setting);
            end
            no_idle = (p == 4);
            feed_text(ITEMS_PER_PHASE);
        end
        no_idle = 1'b0;
        settle();

        if (fail_count == 0 && tokens_pending == 0) begin
            $display("** word_tokenizer_hasher: PASSED **");
        end else begin
            $display("** word_tokenizer_hasher: FAILED **");
        end
        $finish;
    end

    // Hard limit on the run, far above the slowest correct run.
    initial begin
        #(LIMIT_NS);
        $display("** word_tokenizer_hasher: FAILED **");
        $finish;
    end

endmodule

@@ word_tokenizer_hasher.f @@
rtl/core/wth_pkg.sv
rtl/core/wth_datapath.sv
rtl/core/word_tokenizer_hasher.sv
rtl/core/wth_checker.sv
bench/wth_token_checker.sv
bench/word_tokenizer_hasher_tb.sv
